[rtl/rpk_pkg.sv]
`timescale 1ns / 1ps

package rpk_pkg;

   // Field and datapath widths.
   localparam int BYTE_W = 8;
   localparam int WORD_W = 32;
   localparam int OUT_W  = 31;
   localparam int LEN_W  = 5;
   localparam int ACC_W  = OUT_W + WORD_W;
   localparam int CNT_W  = 6;

   // Reset length of an output word.
   localparam logic [LEN_W-1:0] LEN_RESET = 5'd8;

   // Most results that one request may produce.
   localparam logic [CNT_W-1:0] MAX_RESULTS = 6'd32;

   // One unit of work handed from the front to the back.
   typedef struct packed {
      logic              has_word;
      logic [WORD_W-1:0] word;
   } job_type;

   // Back-end status seen by the top level.
   typedef struct packed {
      logic             busy;
      logic [CNT_W-1:0] nbits;
   } status_type;

endpackage

[rtl/rpk_job_queue.sv]
`timescale 1ns / 1ps

module rpk_job_queue
   import rpk_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output job_type pop_data
);

   job_type    mem_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign full     = (count_ff == 2'd2);
   assign valid    = (count_ff != 2'd0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/rpk_front.sv]
`timescale 1ns / 1ps

module rpk_front
   import rpk_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic [BYTE_W-1:0] req_data_byte,
   output logic              req_full,
   output logic              job_push,
   output job_type           job_data,
   input  logic              job_full
);

   logic [23:0] assembly_ff;
   logic [23:0] assembly_in;
   logic [1:0]  bytes_held_ff;
   logic [1:0]  bytes_held_in;
   logic        accept;

   assign req_full = job_full;
   assign accept   = req_push && !job_full;
   assign job_push = accept;

   // Every request becomes one job; the fourth byte completes a word.
   always_comb begin
      assembly_in   = assembly_ff;
      bytes_held_in = bytes_held_ff;
      job_data      = '{has_word: 1'b0, word: {req_data_byte, assembly_ff}};
      if (accept) begin
         if (bytes_held_ff == 2'd3) begin
            job_data.has_word = 1'b1;
            assembly_in       = '0;
            bytes_held_in     = 2'd0;
         end else begin
            unique case (bytes_held_ff)
               2'd0:    assembly_in[7:0]   = req_data_byte;
               2'd1:    assembly_in[15:8]  = req_data_byte;
               default: assembly_in[23:16] = req_data_byte;
            endcase
            bytes_held_in = bytes_held_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         assembly_ff   <= '0;
         bytes_held_ff <= 2'd0;
      end else begin
         assembly_ff   <= assembly_in;
         bytes_held_ff <= bytes_held_in;
      end
   end

endmodule

[rtl/rpk_back.sv]
`timescale 1ns / 1ps

module rpk_back
   import rpk_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [LEN_W-1:0] word_length,
   input  logic             job_valid,
   input  job_type          job_data,
   output logic             job_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [OUT_W-1:0] rsp_word,
   output logic             rsp_last_of_run,
   output status_type       status
);

   logic [ACC_W-1:0] acc_ff;
   logic [ACC_W-1:0] acc_in;
   logic [CNT_W-1:0] nbits_ff;
   logic [CNT_W-1:0] nbits_in;
   logic [CNT_W-1:0] k_ff;
   logic [CNT_W-1:0] k_in;
   logic             busy_ff;
   logic             busy_in;

   logic [CNT_W-1:0] len;
   logic [CNT_W-1:0] rem;
   logic             avail;
   logic             more;
   logic             emit;
   logic             finish;
   logic [OUT_W-1:0] word_out;
   logic [ACC_W-1:0] acc_keep;

   logic [OUT_W-1:0] rq_word_ff [2];
   logic             rq_last_ff [2];
   logic             rq_wr_ff;
   logic             rq_rd_ff;
   logic [1:0]       rq_count_ff;
   logic [1:0]       rq_count_in;
   logic             rq_full;
   logic             rq_pop;

   // A length of zero behaves as one.
   assign len = (word_length == '0) ? CNT_W'(1) : {1'b0, word_length};

   // Cut the next word off the top of the pending bits.
   assign avail    = (nbits_ff >= len) && (k_ff < MAX_RESULTS);
   assign rem      = nbits_ff - len;
   assign more     = (rem >= len) && (k_ff < (MAX_RESULTS - CNT_W'(1)));
   assign emit     = busy_ff && avail && !rq_full;
   assign finish   = busy_ff && (!avail || (emit && !more));
   assign word_out = OUT_W'(acc_ff >> rem) & ~({OUT_W{1'b1}} << len);
   assign acc_keep = acc_ff & ~({ACC_W{1'b1}} << rem);
   assign job_pop  = job_valid && (!busy_ff || finish);

   // Emission, then loading of the next job in the same cycle when possible.
   always_comb begin
      acc_in   = acc_ff;
      nbits_in = nbits_ff;
      k_in     = k_ff;
      busy_in  = busy_ff;
      if (emit) begin
         acc_in   = acc_keep;
         nbits_in = rem;
         k_in     = k_ff + CNT_W'(1);
      end
      if (finish) begin
         busy_in = 1'b0;
      end
      if (job_pop) begin
         busy_in = 1'b1;
         k_in    = '0;
         if (job_data.has_word) begin
            acc_in   = {acc_in[OUT_W-1:0], job_data.word};
            nbits_in = nbits_in + CNT_W'(WORD_W);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         nbits_ff <= '0;
         k_ff     <= '0;
         busy_ff  <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         nbits_ff <= nbits_in;
         k_ff     <= k_in;
         busy_ff  <= busy_in;
      end
   end

   assign status = '{busy: busy_ff, nbits: nbits_ff};

   // Two-entry result queue decouples the back end from the receiver.
   assign rq_full         = (rq_count_ff == 2'd2);
   assign rsp_empty       = (rq_count_ff == 2'd0);
   assign rq_pop          = rsp_pop && !rsp_empty;
   assign rsp_word        = rq_word_ff[rq_rd_ff];
   assign rsp_last_of_run = rq_last_ff[rq_rd_ff];

   always_comb begin
      rq_count_in = rq_count_ff;
      if (emit && !rq_pop) begin
         rq_count_in = rq_count_ff + 2'd1;
      end else if (rq_pop && !emit) begin
         rq_count_in = rq_count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff    <= 1'b0;
         rq_rd_ff    <= 1'b0;
         rq_count_ff <= 2'd0;
      end else begin
         if (emit) begin
            rq_wr_ff <= ~rq_wr_ff;
         end
         if (rq_pop) begin
            rq_rd_ff <= ~rq_rd_ff;
         end
         rq_count_ff <= rq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rq_word_ff[rq_wr_ff] <= word_out;
         rq_last_ff[rq_wr_ff] <= !more;
      end
   end

endmodule

[rtl/byte_stream_to_word_repacker.sv]
`timescale 1ns / 1ps

// Byte stream to variable-width word repacker.
// Requests carry one byte each on req_data_byte and are pushed while req_full
// is low. Every fourth byte completes a 32-bit word (first byte lowest), whose
// bits, most significant first, are cut into results of csr_word_length bits.
// Results appear on rsp_word / rsp_last_of_run while rsp_empty is low and are
// taken with rsp_pop; rsp_last_of_run marks the final result of one request.
// csr_word_length is written through csr_valid / csr_ready (ready is always
// high) and should only change while the block is idle; reset sets it to 8.
// With the back end idle, an accepted request passes through the job queue
// and the back-end accumulator before its first result enters the result
// queue and becomes visible. The extraction shifter cuts one result per cycle
// while the result queue has room, and the back end takes the next request in
// the cycle its last result is produced. A two-entry request queue and a
// two-entry result queue let either side stall: when the receiver stops
// popping, the back end holds, then the request queue fills and req_full
// rises.
// Reset empties both queues and clears all buffered and pending bits.
module byte_stream_to_word_repacker
   import rpk_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic [BYTE_W-1:0] req_data_byte,
   output logic              req_full,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [OUT_W-1:0]  rsp_word,
   output logic              rsp_last_of_run,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [LEN_W-1:0]  csr_word_length
);

   logic [LEN_W-1:0] word_length_ff;
   logic [LEN_W-1:0] word_length_in;
   logic             front_push;
   job_type          front_data;
   logic             queue_full;
   logic             queue_valid;
   job_type          queue_data;
   logic             back_pop;
   status_type       back_status;

   // Configuration register.
   assign csr_ready      = 1'b1;
   assign word_length_in = (csr_valid && csr_ready) ? csr_word_length : word_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         word_length_ff <= LEN_RESET;
      end else begin
         word_length_ff <= word_length_in;
      end
   end

   rpk_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_data_byte (req_data_byte),
      .req_full      (req_full),
      .job_push      (front_push),
      .job_data      (front_data),
      .job_full      (queue_full)
   );

   rpk_job_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_data),
      .full      (queue_full),
      .pop       (back_pop),
      .valid     (queue_valid),
      .pop_data  (queue_data)
   );

   rpk_back u_back (
      .clock           (clock),
      .reset           (reset),
      .word_length     (word_length_ff),
      .job_valid       (queue_valid),
      .job_data        (queue_data),
      .job_pop         (back_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_word        (rsp_word),
      .rsp_last_of_run (rsp_last_of_run),
      .status          (back_status)
   );

   // Between requests fewer than 31 bits remain pending.
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      !back_status.busy |-> (back_status.nbits <= CNT_W'(30)))
      else $error("pending bit count out of range while idle");

   // Reset leaves the result queue empty and the job queue not full.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   // The back end never takes a job that the queue does not hold.
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      back_pop |-> queue_valid)
      else $error("job taken from an empty queue");

endmodule

[bench/byte_stream_to_word_repacker_tb.sv]
`timescale 1ns / 1ps

module byte_stream_to_word_repacker_tb;
   import rpk_pkg::*;

   // Upper bound on the whole run, in clock cycles.
   localparam int unsigned CYCLE_LIMIT = 2000000;
   // Cycles allowed after the last expected word before the block counts as idle.
   localparam int SETTLE_CYCLES = 16;
   // Most words that one byte may release.
   localparam int WORDS_PER_BYTE = 32;

   typedef struct packed {
      logic [OUT_W-1:0] word;
      logic             last_of_run;
   } out_word_type;

   logic              clock;
   logic              reset;
   logic              req_push;
   logic [BYTE_W-1:0] req_data_byte;
   logic              req_full;
   logic              rsp_empty;
   logic              rsp_pop;
   logic [OUT_W-1:0]  rsp_word;
   logic              rsp_last_of_run;
   logic              csr_valid;
   logic              csr_ready;
   logic [LEN_W-1:0]  csr_word_length;

   // Local copy of the repacker state.
   logic [LEN_W-1:0] model_len;
   logic [23:0]      model_assembly;
   logic [1:0]       model_held;
   logic [OUT_W-1:0] model_pending;
   logic [4:0]       model_count;

   out_word_type expected_words[$];

   int errors;
   int bytes_sent;
   int words_checked;
   int length_writes;
   int full_stall_cycles;
   int hold_off_cycles;
   bit tx_steady;
   bit rx_steady;

   byte_stream_to_word_repacker dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_data_byte   (req_data_byte),
      .req_full        (req_full),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_word        (rsp_word),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_word_length (csr_word_length)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Gather one byte and queue every word it releases from the bit stream.
   function automatic void repack_byte(input logic [BYTE_W-1:0] b);
      logic [63:0]  acc;
      int           nbits;
      int           len;
      int           k;
      out_word_type w;
      len   = (model_len == '0) ? 1 : int'(model_len);
      acc   = {33'b0, model_pending};
      nbits = model_count;
      if (model_held == 2'd3) begin
         acc            = (acc << 32) | {32'b0, b, model_assembly};
         nbits          = nbits + 32;
         model_assembly = '0;
         model_held     = 2'd0;
      end else begin
         model_assembly[8 * model_held +: 8] = b;
         model_held = model_held + 2'd1;
      end
      k = 0;
      while (nbits >= len && k < WORDS_PER_BYTE) begin
         nbits         = nbits - len;
         w.word        = OUT_W'((acc >> nbits) & ((64'd1 << len) - 64'd1));
         acc           = acc & ((64'd1 << nbits) - 64'd1);
         k             = k + 1;
         w.last_of_run = !(nbits >= len && k < WORDS_PER_BYTE);
         expected_words.push_back(w);
      end
      model_pending = acc[OUT_W-1:0];
      model_count   = nbits[4:0];
   endfunction

   // Sample all handshakes at the rising edge: predict on accepted requests,
   // compare each popped word against the oldest expectation.
   always @(posedge clock) begin : scoreboard
      out_word_type exp_w;
      if (!reset) begin
         if (csr_valid && csr_ready) model_len = csr_word_length;
         if (req_push && req_full) full_stall_cycles++;
         if (req_push && !req_full) repack_byte(req_data_byte);
         if (rsp_pop && !rsp_empty) begin
            if (expected_words.size() == 0) begin
               $error("rsp_word %h arrived with no word expected", rsp_word);
               errors++;
            end else begin
               exp_w = expected_words.pop_front();
               words_checked++;
               if (rsp_word !== exp_w.word) begin
                  $error("rsp_word: expected %h, actual %h", exp_w.word, rsp_word);
                  errors++;
               end
               if (rsp_last_of_run !== exp_w.last_of_run) begin
                  $error("rsp_last_of_run: expected %b, actual %b",
                         exp_w.last_of_run, rsp_last_of_run);
                  errors++;
               end
            end
         end
      end
   end

   // Result side: a requested hold-off first, then random stalls.
   initial begin : result_sink
      int stall;
      stall   = 0;
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_pop <= 1'b0;
            hold_off_cycles--;
         end else if (stall > 0) begin
            rsp_pop <= 1'b0;
            stall--;
         end else begin
            rsp_pop <= 1'b1;
            if (!rx_steady && $urandom_range(0, 3) == 0) stall = pick_gap();
         end
      end
   end

   // Watchdog on the cycle count.
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("byte_stream_to_word_repacker regression: fail");
      $finish;
   end

   // Offer one request and hold it until accepted, then maybe idle.
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      int gap;
      @(negedge clock);
      req_push      <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (req_full);
      bytes_sent++;
      gap = tx_steady ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_push <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic send_random_bytes(input int count);
      repeat (count) send_byte(BYTE_W'($urandom_range(0, 255)));
   endtask

   // Stop offering requests and wait until every expected word is out.
   task automatic drain_results();
      @(negedge clock);
      req_push <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Length changes only go in while the block is idle.
   task automatic write_word_length(input logic [LEN_W-1:0] len);
      drain_results();
      @(negedge clock);
      csr_valid       <= 1'b1;
      csr_word_length <= len;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      length_writes++;
   endtask

   // Reset length of 8 with all-zero, all-one and single-bit bytes.
   task automatic test_default_length();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h80);
      send_byte(8'h01);
   endtask

   // A word completing at length 1 with bits pending hits the per-byte cap;
   // the leftover bits go out with the next byte.
   task automatic test_result_cap();
      write_word_length(5'd17);
      send_byte(8'hA5);
      send_byte(8'h5A);
      send_byte(8'h3C);
      send_byte(8'hC3);
      send_byte(8'h0F);
      send_byte(8'hF0);
      send_byte(8'h7E);
      write_word_length(5'd1);
      send_byte(8'h81);
      send_byte(8'h42);
   endtask

   // Shorter lengths drain pending bits on a byte that completes no word;
   // length zero acts as length one; length 31 at the top end.
   task automatic test_length_changes();
      write_word_length(5'd20);
      send_byte(8'h11);
      send_byte(8'h22);
      send_byte(8'h33);
      write_word_length(5'd5);
      send_byte(8'h99);
      write_word_length(5'd0);
      send_byte(8'h66);
      write_word_length(5'd31);
      send_byte(8'hFF);
      send_byte(8'hFE);
   endtask

   // Random bytes over a series of lengths and idling mixes.
   task automatic test_random_lengths();
      logic [LEN_W-1:0] len;
      for (int p = 0; p < 10; p++) begin
         case (p)
            0:       len = 5'd1;
            1:       len = 5'd31;
            2:       len = 5'd0;
            default: len = LEN_W'($urandom_range(1, 31));
         endcase
         tx_steady = (p % 3 == 0);
         rx_steady = (p % 4 == 1);
         write_word_length(len);
         send_random_bytes(20);
      end
      tx_steady = 1'b0;
      rx_steady = 1'b0;
   endtask

   // Receiver stops for a long stretch while bytes keep coming at length 1,
   // so both queues fill and the input stalls.
   task automatic test_receiver_hold_off();
      write_word_length(5'd1);
      tx_steady       = 1'b1;
      hold_off_cycles = 400;
      send_random_bytes(40);
      tx_steady = 1'b0;
   endtask

   initial begin
      reset             = 1'b1;
      req_push          = 1'b0;
      req_data_byte     = '0;
      csr_valid         = 1'b0;
      csr_word_length   = '0;
      errors            = 0;
      bytes_sent        = 0;
      words_checked     = 0;
      length_writes     = 0;
      full_stall_cycles = 0;
      hold_off_cycles   = 0;
      tx_steady         = 1'b0;
      rx_steady         = 1'b0;
      model_len         = LEN_RESET;
      model_assembly    = '0;
      model_held        = '0;
      model_pending     = '0;
      model_count       = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_length();
      test_result_cap();
      test_length_changes();
      test_random_lengths();
      test_receiver_hold_off();
      drain_results();

      $display("Sent %0d bytes, %0d length writes (0, 1, 31, mid), %0d words checked.",
               bytes_sent, length_writes, words_checked);
      $display("Input held off by a full queue for %0d cycles; %0d mismatches.",
               full_stall_cycles, errors);
      if (errors == 0) begin
         $display("byte_stream_to_word_repacker regression: pass");
      end else begin
         $display("byte_stream_to_word_repacker regression: fail");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/rpk_pkg.sv
rtl/rpk_job_queue.sv
rtl/rpk_front.sv
rtl/rpk_back.sv
rtl/byte_stream_to_word_repacker.sv
bench/byte_stream_to_word_repacker_tb.sv
